>>> src/bwc_pkg.sv
// Shared types and constants of the boost window controller.
`default_nettype none

package bwc_pkg;

  // Default number of devices handled by one controller.
  localparam int NUM_DEVICES_DEFAULT = 2;

  // Field widths.
  localparam int CMD_W   = 3;
  localparam int DEV_W   = 3;
  localparam int TICKS_W = 16;
  localparam int FREQ_W  = 32;
  localparam int MASK_W  = 8;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 32;

  // Commands carried in the input tuser field.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_KICK_ALL   = 3'd1,
    CMD_KICK_ONE   = 3'd2,
    CMD_MAX_KICK   = 3'd3,
    CMD_SCREEN_ON  = 3'd4,
    CMD_SCREEN_OFF = 3'd5
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    REG_KICK_FREQ    = 3'd0,
    REG_LOWEST_FREQ  = 3'd1,
    REG_CEILING_FREQ = 3'd2,
    REG_INPUT_TICKS  = 3'd3,
    REG_WAKE_TICKS   = 3'd4,
    REG_ENABLE_MASK  = 3'd5
  } cfg_reg_t;

  // Register reset values.
  localparam logic [FREQ_W-1:0]  KICK_FREQ_RST    = 32'd0;
  localparam logic [FREQ_W-1:0]  LOWEST_FREQ_RST  = 32'd0;
  localparam logic [FREQ_W-1:0]  CEILING_FREQ_RST = 32'hFFFF_FFFF;
  localparam logic [TICKS_W-1:0] INPUT_TICKS_RST  = 16'd64;
  localparam logic [TICKS_W-1:0] WAKE_TICKS_RST   = 16'd1000;
  localparam logic [MASK_W-1:0]  ENABLE_MASK_RST  = 8'd0;

  // One countdown window: running flag and ticks left.
  typedef struct packed {
    logic               on;
    logic [TICKS_W-1:0] rem;
  } window_t;

  // Per-device state as held in the state memory.
  typedef struct packed {
    logic    display_off;
    window_t input_win;
    window_t max_win;
  } dev_entry_t;

  localparam int ENTRY_W = $bits(dev_entry_t);

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

>>> src/bwc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/boost_window_controller.sv
// Top level of the boost window controller: sequencer, state memory and result path.
//
// Usage. Input items arrive on s_tvalid/s_tready: s_tuser carries the command,
// s_tdata the target device and the max boost length. Result items leave on
// m_tvalid/m_tready: m_tdata carries the device, its new floor frequency and
// its max boost flag; m_tlast marks the final result caused by an input item.
// An input item causes between zero and NUM_DEVICES results, in ascending
// device order. Configuration registers are written through cfg_valid,
// cfg_index and cfg_data, which are always ready; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// Per-device state sits in a small memory with registered read data; each
// input item is accepted, then visits every device with a read step and a
// modify/write step, then ends with a final flush of the last result. A result
// reaches the output register once the next result is known or at the flush.
// The next item is accepted only after the flush, but a result may still be
// waiting in the output register then. When the receiver stalls, one result
// is held back in a pending slot and the sequencer waits until the output
// register frees. Reset clears the valid bits of the state memory, so every
// device reads as screen on with no boost running, and restores the
// register reset values.
`default_nettype none

module boost_window_controller #(
  parameter int NUM_DEVICES = bwc_pkg::NUM_DEVICES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input items.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [2:0] device_index, [18:3] duration_ticks, rest zero
  input  wire logic [2:0]  s_tuser,   // [2:0] command
  // Result items.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // [2:0] device_number, [34:3] min_frequency,
                                      // [35] max_boost_on, rest zero
  output logic             m_tlast,   // last_result
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int DW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam logic [DW-1:0] LAST_DEV = DW'(NUM_DEVICES - 1);

  // Configuration registers.
  logic [bwc_pkg::FREQ_W-1:0]  kick_freq;
  logic [bwc_pkg::FREQ_W-1:0]  lowest_freq;
  logic [bwc_pkg::FREQ_W-1:0]  ceiling_freq;
  logic [bwc_pkg::TICKS_W-1:0] input_ticks;
  logic [bwc_pkg::TICKS_W-1:0] wake_ticks;
  logic [bwc_pkg::MASK_W-1:0]  enable_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kick_freq    <= bwc_pkg::KICK_FREQ_RST;
      lowest_freq  <= bwc_pkg::LOWEST_FREQ_RST;
      ceiling_freq <= bwc_pkg::CEILING_FREQ_RST;
      input_ticks  <= bwc_pkg::INPUT_TICKS_RST;
      wake_ticks   <= bwc_pkg::WAKE_TICKS_RST;
      enable_mask  <= bwc_pkg::ENABLE_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bwc_pkg::REG_KICK_FREQ:    kick_freq    <= cfg_data;
        bwc_pkg::REG_LOWEST_FREQ:  lowest_freq  <= cfg_data;
        bwc_pkg::REG_CEILING_FREQ: ceiling_freq <= cfg_data;
        bwc_pkg::REG_INPUT_TICKS:  input_ticks  <= cfg_data[15:0];
        bwc_pkg::REG_WAKE_TICKS:   wake_ticks   <= cfg_data[15:0];
        bwc_pkg::REG_ENABLE_MASK:  enable_mask  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer and item registers.
  bwc_pkg::state_t state_q, state_next;
  logic [2:0]                  cmd_q;
  logic [2:0]                  idx_q;
  logic [bwc_pkg::TICKS_W-1:0] dur_q;
  logic [DW-1:0]               dev_q;

  // State memory and its valid bits.
  logic [NUM_DEVICES-1:0]      vld;
  logic                        rd_vld_q;
  logic                        ram_we;
  logic                        ram_re;
  logic [bwc_pkg::ENTRY_W-1:0] ram_rdata;
  bwc_pkg::dev_entry_t         cur;
  bwc_pkg::dev_entry_t         upd;

  bwc_ram #(
    .WIDTH (bwc_pkg::ENTRY_W),
    .DEPTH (NUM_DEVICES)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dev_q),
    .wdata (upd),
    .re    (ram_re),
    .raddr (dev_q),
    .rdata (ram_rdata)
  );

  // Pending result and output register.
  logic                       pend_valid;
  logic [DW-1:0]              pend_dev;
  logic [bwc_pkg::FREQ_W-1:0] pend_freq;
  logic                       pend_max;
  logic                       out_valid;
  logic [DW-1:0]              out_dev;
  logic [bwc_pkg::FREQ_W-1:0] out_freq;
  logic                       out_max;
  logic                       out_last;

  // Window helpers.
  function automatic bwc_pkg::window_t count_down(bwc_pkg::window_t w);
    bwc_pkg::window_t r;
    r = w;
    if (w.on) begin
      if (w.rem <= 16'd1) begin
        r.on  = 1'b0;
        r.rem = '0;
      end else begin
        r.rem = w.rem - 16'd1;
      end
    end
    return r;
  endfunction

  // A device never written since reset reads as all zero.
  assign cur = rd_vld_q ? bwc_pkg::dev_entry_t'(ram_rdata) : '0;

  logic dev_en;
  logic is_target;
  logic emit;
  logic changed;
  logic out_free;
  logic advance;
  logic load_mid;
  logic load_final;
  logic [bwc_pkg::FREQ_W-1:0] capped_freq;
  logic [bwc_pkg::FREQ_W-1:0] new_freq;
  logic new_max;

  assign dev_en    = enable_mask[dev_q];
  assign is_target = (idx_q == {{(3 - DW){1'b0}}, dev_q});

  // Read-modify step for the device being visited.
  always_comb begin
    upd = cur;
    case (cmd_q)
      bwc_pkg::CMD_TICK: begin
        upd.input_win = count_down(cur.input_win);
        upd.max_win   = count_down(cur.max_win);
      end
      bwc_pkg::CMD_KICK_ALL: begin
        if (dev_en && !cur.display_off) begin
          upd.input_win.on  = 1'b1;
          upd.input_win.rem = input_ticks;
        end
      end
      bwc_pkg::CMD_KICK_ONE: begin
        if (is_target && dev_en && !cur.display_off) begin
          upd.input_win.on  = 1'b1;
          upd.input_win.rem = input_ticks;
        end
      end
      bwc_pkg::CMD_MAX_KICK: begin
        if (is_target && dev_en && !cur.display_off && !(cur.max_win.rem > dur_q)) begin
          upd.max_win.on  = 1'b1;
          upd.max_win.rem = dur_q;
        end
      end
      bwc_pkg::CMD_SCREEN_ON: begin
        // Screen-off is cleared before the wake boost is tried.
        upd.display_off = 1'b0;
        if (dev_en && !(cur.max_win.rem > wake_ticks)) begin
          upd.max_win.on  = 1'b1;
          upd.max_win.rem = wake_ticks;
        end
      end
      bwc_pkg::CMD_SCREEN_OFF: begin
        upd.display_off = 1'b1;
      end
      default: ;
    endcase
  end

  // Result value for the visited device.
  assign changed = (upd.display_off != cur.display_off)
                || (upd.input_win.on != cur.input_win.on)
                || (upd.max_win.on != cur.max_win.on);
  assign emit        = dev_en && changed;
  assign capped_freq = (kick_freq < ceiling_freq) ? kick_freq : ceiling_freq;
  assign new_freq    = (!upd.display_off && upd.input_win.on) ? capped_freq : lowest_freq;
  assign new_max     = !upd.display_off && upd.max_win.on;

  assign out_free = !out_valid || m_tready;
  // A new result can only be kept once the older pending one has somewhere to go.
  assign advance  = !emit || !pend_valid || out_free;

  // Next state.
  always_comb begin
    state_next = state_q;
    case (state_q)
      bwc_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = bwc_pkg::ST_READ;
        end
      end
      bwc_pkg::ST_READ: begin
        state_next = bwc_pkg::ST_MODIFY;
      end
      bwc_pkg::ST_MODIFY: begin
        if (advance) begin
          state_next = (dev_q == LAST_DEV) ? bwc_pkg::ST_FLUSH : bwc_pkg::ST_READ;
        end
      end
      bwc_pkg::ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = bwc_pkg::ST_IDLE;
        end
      end
      default: state_next = bwc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_tready   = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    load_mid   = 1'b0;
    load_final = 1'b0;
    case (state_q)
      bwc_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      bwc_pkg::ST_READ: begin
        ram_re = 1'b1;
      end
      bwc_pkg::ST_MODIFY: begin
        ram_we   = advance;
        load_mid = advance && emit && pend_valid;
      end
      bwc_pkg::ST_FLUSH: begin
        load_final = pend_valid && out_free;
      end
      default: ;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= bwc_pkg::ST_IDLE;
      dev_q   <= '0;
    end else begin
      state_q <= state_next;
      if (state_q == bwc_pkg::ST_IDLE) begin
        dev_q <= '0;
      end else if (state_q == bwc_pkg::ST_MODIFY && advance && dev_q != LAST_DEV) begin
        dev_q <= dev_q + DW'(1);
      end
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_q <= s_tuser;
      idx_q <= s_tdata[2:0];
      dur_q <= s_tdata[18:3];
    end
  end

  // Valid bits of the state memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ram_we) begin
      vld[dev_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_vld_q <= vld[dev_q];
    end
  end

  // Pending result slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (ram_we && emit) begin
      pend_valid <= 1'b1;
    end else if (load_final) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we && emit) begin
      pend_dev  <= dev_q;
      pend_freq <= new_freq;
      pend_max  <= new_max;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_mid || load_final) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_mid || load_final) begin
      out_dev  <= pend_dev;
      out_freq <= pend_freq;
      out_max  <= pend_max;
      out_last <= load_final;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {4'd0, out_max, out_freq, {(3 - DW){1'b0}}, out_dev};

endmodule

`default_nettype wire
